### src/sas_pkg.sv
// ----------------------------------------------------------------------------
// sas_pkg: shared types and constants for the suffix absolute area sum block
// Request payloads, result payloads, field widths and accumulator control.
// ----------------------------------------------------------------------------
package sas_pkg;

    localparam int MAX_DIM_DEF = 16;
    localparam int SIZE_W      = 5;
    localparam int IDX_W       = 4;
    localparam int DATA_W      = 16;
    localparam int SUM_W       = 24;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic                     kind;
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic signed [DATA_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [SUM_W-1:0] abs_sum;
        logic             any_negative;
    } out_item_t;

    typedef struct packed {
        logic clear;      // start of a new query
        logic take;       // read data this cycle belongs to the scan
        logic in_region;  // element lies in the lower-right region
    } accum_ctrl_t;

endpackage

### src/sas_ram.sv
// ----------------------------------------------------------------------------
// sas_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module sas_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/sas_accum.sv
// ----------------------------------------------------------------------------
// sas_accum: scan accumulator
// Saturating sum of magnitudes over the region and a negative-element flag.
// ----------------------------------------------------------------------------
module sas_accum (
    input  logic                         clk,
    input  logic                         rst_n,
    input  sas_pkg::accum_ctrl_t         ctrl,
    input  logic [sas_pkg::DATA_W-1:0]   rd_data,
    output logic [sas_pkg::SUM_W-1:0]    sum,
    output logic                         neg
);
    import sas_pkg::*;

    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic              neg_reg, neg_next;
    logic [DATA_W:0]   mag;
    logic [SUM_W:0]    sum_wide;

    // two's complement magnitude; the most negative value gives 0x8000 exactly
    assign mag = rd_data[DATA_W-1] ? ((DATA_W+1)'(1) << DATA_W) - {1'b0, rd_data}
                                   : {1'b0, rd_data};
    assign sum_wide = {1'b0, sum_reg} + (SUM_W+1)'(mag);

    always_comb
    begin
        sum_next = sum_reg;
        neg_next = neg_reg;
        if (ctrl.clear)
        begin
            sum_next = '0;
            neg_next = 1'b0;
        end
        else if (ctrl.take)
        begin
            if (rd_data[DATA_W-1])
            begin
                neg_next = 1'b1;
            end
            if (ctrl.in_region)
            begin
                sum_next = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            neg_reg <= 1'b0;
        end
        else
        begin
            sum_reg <= sum_next;
            neg_reg <= neg_next;
        end
    end

    assign sum = sum_reg;
    assign neg = neg_reg;

endmodule

### src/suffix_abs_area_sum.sv
// ----------------------------------------------------------------------------
// suffix_abs_area_sum: suffix sum of absolute values over a square matrix
// Element store in one RAM; writes update a negative count, queries scan.
// ----------------------------------------------------------------------------
//
//  channel | dir | payload       | request
//  --------+-----+---------------+------------------------------------------
//  cfg     | in  | cfg_data (5b) | new matrix_size, always taken
//  in      | in  | in_item_t     | kind 0 writes one element, 1 queries
//  out     | out | out_item_t    | one result per query, none per write
//
//  After reset the store is zeroed by a sweep over all MAX_DIM*MAX_DIM
//  entries, one entry a cycle; in_ready stays low until it ends.
//  A write inside the active square reads the old element, then writes
//  the new one back with the negative-count update (read-modify-write on
//  the single RAM). A query inside the active square makes one RAM read per
//  element of the n*n square, n = min(matrix_size, MAX_DIM), then passes a
//  drain state for the read latency and a done state that loads the result
//  register. A query outside the active square skips the scan, answers zero.
//  The output register holds one result. While it is full and out_ready is
//  low, a finishing query waits in its last cycle with in_ready low; new
//  requests are taken only once the sequencer is back to idle.
// ----------------------------------------------------------------------------
module suffix_abs_area_sum #(
    parameter int MAX_DIM = sas_pkg::MAX_DIM_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [sas_pkg::SIZE_W-1:0]  cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  sas_pkg::in_item_t           in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output sas_pkg::out_item_t          out_data
);
    import sas_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(MAX_DIM + 1);
    localparam int NCW   = $clog2(DEPTH + 1);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_WB    = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [SIZE_W-1:0] size_reg;
    logic [AW-1:0]     clr_addr_reg, clr_addr_next;
    logic [CW-1:0]     r_reg, r_next, c_reg, c_next;
    logic              take_reg, take_next;
    logic              region_reg, region_next;
    logic [NCW-1:0]    neg_cnt_reg, neg_cnt_next;
    logic              out_valid_reg;
    out_item_t         out_data_reg;

    // payload registers, no reset
    logic [AW-1:0]     wr_addr_reg;
    logic [DATA_W-1:0] wr_val_reg;
    logic [IDX_W-1:0]  q_row_reg, q_col_reg;

    logic [CW-1:0]     act_n;
    logic              in_fire, in_square, c_last, r_last, out_free, done_load;
    logic [AW-1:0]     in_addr, scan_addr, rd_addr, mem_waddr;
    logic [DATA_W-1:0] mem_wdata, rd_data;
    logic              mem_we;
    logic [SUM_W-1:0]  acc_sum;
    logic              acc_neg;
    accum_ctrl_t       acc_ctrl;

    // active size saturates at MAX_DIM
    assign act_n = (int'(size_reg) > MAX_DIM) ? CW'(MAX_DIM) : CW'(size_reg);

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid & in_ready;
    assign in_square = (int'(in_data.row) < int'(act_n)) && (int'(in_data.col) < int'(act_n));

    assign in_addr   = AW'(int'(in_data.row) * MAX_DIM + int'(in_data.col));
    assign scan_addr = AW'(int'(r_reg) * MAX_DIM + int'(c_reg));
    assign rd_addr   = (state_reg == ST_SCAN) ? scan_addr : in_addr;

    assign c_last = (c_reg == act_n - CW'(1));
    assign r_last = (r_reg == act_n - CW'(1));

    assign out_free  = !out_valid_reg || out_ready;
    assign done_load = (state_reg == ST_DONE) && out_free;

    // RAM write port: clearing sweep or write-back of a write request
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = wr_addr_reg;
        mem_wdata = wr_val_reg;
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end
        else if (state_reg == ST_WB)
        begin
            mem_we = 1'b1;
        end
    end

    sas_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign acc_ctrl.clear     = in_fire && (in_data.kind == KIND_QUERY);
    assign acc_ctrl.take      = take_reg;
    assign acc_ctrl.in_region = region_reg;

    sas_accum u_accum (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (acc_ctrl),
        .rd_data (rd_data),
        .sum     (acc_sum),
        .neg     (acc_neg)
    );

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        r_next        = r_reg;
        c_next        = c_reg;
        take_next     = 1'b0;
        region_next   = 1'b0;
        neg_cnt_next  = neg_cnt_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    r_next = '0;
                    c_next = '0;
                    if (in_data.kind == KIND_WRITE)
                    begin
                        if (in_square)
                        begin
                            state_next = ST_WB;
                        end
                    end
                    else
                    begin
                        state_next = in_square ? ST_SCAN : ST_DONE;
                    end
                end
            end
            ST_WB:
            begin
                // old element arrives now
                neg_cnt_next = neg_cnt_reg - NCW'(rd_data[DATA_W-1])
                                           + NCW'(wr_val_reg[DATA_W-1]);
                state_next   = ST_IDLE;
            end
            ST_SCAN:
            begin
                take_next   = 1'b1;
                region_next = (int'(r_reg) >= int'(q_row_reg))
                           && (int'(c_reg) >= int'(q_col_reg));
                if (c_last)
                begin
                    c_next = '0;
                    r_next = r_reg + CW'(1);
                    if (r_last)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
                else
                begin
                    c_next = c_reg + CW'(1);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            size_reg      <= SIZE_RESET;
            clr_addr_reg  <= '0;
            r_reg         <= '0;
            c_reg         <= '0;
            take_reg      <= 1'b0;
            region_reg    <= 1'b0;
            neg_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            r_reg        <= r_next;
            c_reg        <= c_next;
            take_reg     <= take_next;
            region_reg   <= region_next;
            neg_cnt_reg  <= neg_cnt_next;
            if (cfg_valid && cfg_ready)
            begin
                size_reg <= cfg_data;
            end
            if (done_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            wr_addr_reg <= in_addr;
            wr_val_reg  <= in_data.value;
            q_row_reg   <= in_data.row;
            q_col_reg   <= in_data.col;
        end
        if (done_load)
        begin
            // flag needs a negative element in the square and a nonzero count
            out_data_reg.abs_sum      <= acc_sum;
            out_data_reg.any_negative <= acc_neg && (neg_cnt_reg != '0);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### tb/suffix_abs_area_sum_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// suffix_abs_area_sum_tb: self-checking bench for the suffix abs area sum
// A short directed table, then random write/query traffic across a range of
// matrix sizes. A behavioral model of the element store predicts the query
// results the table does not give; the scoreboard checks out_data per field.
// ----------------------------------------------------------------------------
module suffix_abs_area_sum_tb;

    import sas_pkg::*;

    localparam int DIM           = MAX_DIM_DEF;
    localparam int SETTLE_CYCLES = 8;      // covers a write still in its RMW
    localparam int DRAIN_CYCLES  = 20;
    localparam int HOLD_CYCLES   = 1500;   // long receiver hold-off
    localparam int IDLE_LIMIT    = 20000;  // cycles with no handshake at all
    localparam int IDLE_PCT      = 32;
    localparam int QUERY_PCT     = 45;
    localparam int WIDE_IDX_PCT  = 12;     // indexes drawn anywhere in the store

    // One row of the directed table. When typed is set, want is the result
    // read straight off the behavior; otherwise the predictor supplies it.
    typedef struct {
        logic [SIZE_W-1:0] size;
        in_item_t          req;
        bit                typed;
        out_item_t         want;
    } dir_row_t;

    // One phase of random traffic.
    typedef struct {
        logic [SIZE_W-1:0] size;
        int                items;
        int                neg_pct;   // share of negative values written
        bit                steady;    // no idling on either side
        bit                hold;      // receiver holds off for a long stretch
    } phase_t;

    localparam int DIR_ROWS = 25;
    localparam int PHASES   = 11;

    logic              clk;
    logic              rst_n;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [SIZE_W-1:0] cfg_data;
    logic              in_valid;
    logic              in_ready;
    in_item_t          in_data;
    logic              out_valid;
    logic              out_ready;
    out_item_t         out_data;

    // Model of the block: element store, negative count, size register.
    logic [DATA_W-1:0] elem_mem [DIM*DIM];
    int                neg_elems;
    logic [SIZE_W-1:0] size_reg;

    // Query results still to come out, oldest first.
    out_item_t         sum_expect_q [$];

    int                errors;
    int                stall_cycles;
    bit                steady_flow;
    bit                hold_req;
    bit                hold_done;

    dir_row_t directed_tbl [DIR_ROWS] = '{
        // cleared store answers zero at both corners
        '{5'd16, '{KIND_QUERY, 4'd0,  4'd0,  16'h0000}, 1'b1, '{24'd0,     1'b0}},
        '{5'd16, '{KIND_QUERY, 4'd15, 4'd15, 16'h0000}, 1'b1, '{24'd0,     1'b0}},
        // most negative value: magnitude 32768 is exact
        '{5'd16, '{KIND_WRITE, 4'd0,  4'd0,  16'h8000}, 1'b0, '{24'd0,     1'b0}},
        '{5'd16, '{KIND_QUERY, 4'd0,  4'd0,  16'h0000}, 1'b1, '{24'd32768, 1'b1}},
        // most positive value in the far corner
        '{5'd16, '{KIND_WRITE, 4'd15, 4'd15, 16'h7FFF}, 1'b0, '{24'd0,     1'b0}},
        '{5'd16, '{KIND_QUERY, 4'd15, 4'd15, 16'h0000}, 1'b1, '{24'd32767, 1'b1}},
        '{5'd16, '{KIND_QUERY, 4'd0,  4'd0,  16'h0000}, 1'b1, '{24'd65535, 1'b1}},
        // overwrite the only negative: flag drops, value on a query is ignored
        '{5'd16, '{KIND_WRITE, 4'd0,  4'd0,  16'h0000}, 1'b0, '{24'd0,     1'b0}},
        '{5'd16, '{KIND_QUERY, 4'd1,  4'd1,  16'hFFFF}, 1'b1, '{24'd32767, 1'b0}},
        '{5'd16, '{KIND_WRITE, 4'd15, 4'd0,  16'hFFFF}, 1'b0, '{24'd0,     1'b0}},
        '{5'd16, '{KIND_QUERY, 4'd15, 4'd0,  16'h0000}, 1'b1, '{24'd32768, 1'b1}},
        '{5'd16, '{KIND_WRITE, 4'd0,  4'd15, 16'h0100}, 1'b0, '{24'd0,     1'b0}},
        '{5'd16, '{KIND_QUERY, 4'd0,  4'd15, 16'h0000}, 1'b0, '{24'd0,     1'b0}},
        '{5'd16, '{KIND_WRITE, 4'd15, 4'd0,  16'h0005}, 1'b0, '{24'd0,     1'b0}},
        '{5'd16, '{KIND_QUERY, 4'd0,  4'd0,  16'h0000}, 1'b0, '{24'd0,     1'b0}},
        // write and query outside the active square, then a write inside
        '{5'd4,  '{KIND_WRITE, 4'd5,  4'd5,  16'hFFF9}, 1'b0, '{24'd0,     1'b0}},
        '{5'd4,  '{KIND_QUERY, 4'd5,  4'd5,  16'h0000}, 1'b1, '{24'd0,     1'b0}},
        '{5'd4,  '{KIND_WRITE, 4'd2,  4'd2,  16'hFED4}, 1'b0, '{24'd0,     1'b0}},
        '{5'd4,  '{KIND_QUERY, 4'd3,  4'd3,  16'h0000}, 1'b0, '{24'd0,     1'b0}},
        // size 2 hides the negative at (2,2) from the flag, size 3 shows it
        '{5'd2,  '{KIND_QUERY, 4'd0,  4'd0,  16'h0000}, 1'b1, '{24'd0,     1'b0}},
        '{5'd3,  '{KIND_QUERY, 4'd1,  4'd1,  16'h0000}, 1'b1, '{24'd300,   1'b1}},
        // size zero: write ignored, query answers zero
        '{5'd0,  '{KIND_WRITE, 4'd0,  4'd0,  16'hFFFF}, 1'b0, '{24'd0,     1'b0}},
        '{5'd0,  '{KIND_QUERY, 4'd0,  4'd0,  16'h0000}, 1'b1, '{24'd0,     1'b0}},
        // size above the maximum saturates
        '{5'd31, '{KIND_QUERY, 4'd0,  4'd0,  16'h0000}, 1'b0, '{24'd0,     1'b0}},
        '{5'd1,  '{KIND_QUERY, 4'd0,  4'd0,  16'h0000}, 1'b1, '{24'd0,     1'b0}}
    };

    // Most traffic runs at small sizes; a full 16x16 scan reads 256 elements.
    phase_t phase_tbl [PHASES] = '{
        '{5'd1,  120, 30, 1'b0, 1'b0},
        '{5'd2,  150, 10, 1'b0, 1'b0},
        '{5'd4,  200, 25, 1'b0, 1'b1},
        '{5'd3,  150, 50, 1'b1, 1'b0},
        '{5'd16, 120, 20, 1'b0, 1'b0},
        '{5'd0,   50, 50, 1'b0, 1'b0},
        '{5'd5,  150,  5, 1'b0, 1'b0},
        '{5'd31,  80, 30, 1'b0, 1'b0},
        '{5'd8,  150, 15, 1'b0, 1'b0},
        '{5'd6,  130, 40, 1'b0, 1'b0},
        '{5'd12, 100, 20, 1'b0, 1'b0}
    };

    suffix_abs_area_sum #(
        .MAX_DIM (DIM)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Active rows and columns; the register saturates at the store size.
    function automatic int unsigned active_dim();
        return (size_reg > DIM) ? DIM : int'(size_reg);
    endfunction

    // Apply one accepted request to the model. A write inside the active
    // square updates the store and the negative count; a query inside it
    // scans it all for the flag and sums magnitudes from (row, col) down-right.
    task automatic apply_request(input in_item_t req, output bit answers,
                                 output out_item_t res);
        int unsigned       n;
        int unsigned       at;
        int unsigned       sum;
        bit                neg;
        bit                in_square;
        logic [DATA_W-1:0] e;
        n         = active_dim();
        in_square = (req.row < n) && (req.col < n);
        at        = req.row * DIM + req.col;
        answers   = (req.kind == KIND_QUERY);
        res       = '0;
        if (!answers)
        begin
            if (in_square)
            begin
                if (elem_mem[at][DATA_W-1])
                    neg_elems--;
                if (req.value[DATA_W-1])
                    neg_elems++;
                elem_mem[at] = req.value;
            end
            return;
        end
        if (!in_square)
            return;
        sum = 0;
        neg = 1'b0;
        for (int unsigned r = 0; r < n; r++)
        begin
            for (int unsigned c = 0; c < n; c++)
            begin
                e = elem_mem[r * DIM + c];
                if (e[DATA_W-1])
                    neg = 1'b1;
                if (r >= req.row && c >= req.col)
                begin
                    // two's complement magnitude, 0x8000 maps to 32768
                    sum += e[DATA_W-1] ? (32'h10000 - {16'h0, e}) : {16'h0, e};
                    if (sum > 32'hFFFFFF)
                        sum = 32'hFFFFFF;
                end
            end
        end
        if (neg_elems == 0)
            neg = 1'b0;
        res.abs_sum      = sum[SUM_W-1:0];
        res.any_negative = neg;
    endtask

    function automatic logic [DATA_W-1:0] pick_value(input int neg_pct);
        if ($urandom_range(0, 99) < neg_pct)
        begin
            case ($urandom_range(0, 3))
                0:       return 16'h8000;
                1:       return 16'hFFFF;
                default: return 16'h8000 | 16'($urandom_range(0, 16'h7FFF));
            endcase
        end
        case ($urandom_range(0, 3))
            0:       return 16'h0000;
            1:       return 16'h7FFF;
            2:       return 16'($urandom_range(0, 16'h01FF));
            default: return 16'($urandom_range(0, 16'h7FFF));
        endcase
    endfunction

    // Indexes mostly land inside the active square, a share anywhere.
    function automatic in_item_t rand_request(input int unsigned n, input int neg_pct);
        in_item_t r;
        bit       wide;
        wide    = (n == 0) || ($urandom_range(0, 99) < WIDE_IDX_PCT);
        r.kind  = ($urandom_range(0, 99) < QUERY_PCT) ? KIND_QUERY : KIND_WRITE;
        r.row   = wide ? IDX_W'($urandom_range(0, DIM - 1)) : IDX_W'($urandom_range(0, n - 1));
        r.col   = wide ? IDX_W'($urandom_range(0, DIM - 1)) : IDX_W'($urandom_range(0, n - 1));
        r.value = pick_value(neg_pct);
        return r;
    endfunction

    // Offer one request, hold it until taken, then feed the model. Idle
    // cycles go in front of the request so valid never drops once raised.
    task automatic send_req(input in_item_t req, input bit typed, input out_item_t typed_res);
        bit        answers;
        out_item_t res;
        if (!steady_flow)
        begin
            while ($urandom_range(0, 99) < IDLE_PCT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_data  <= req;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        apply_request(req, answers, res);
        if (answers)
            sum_expect_q.push_back(typed ? typed_res : res);
    endtask

    // Size changes only with the block idle: every result back, then a few
    // cycles for a trailing write that gives no result.
    task automatic set_size(input logic [SIZE_W-1:0] sz);
        in_valid <= 1'b0;
        while (sum_expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_data  <= sz;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        size_reg = sz;
    endtask

    // Stimulus: reset, directed table, then the random phases.
    initial
    begin
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        in_data     = '0;
        errors      = 0;
        steady_flow = 1'b0;
        hold_req    = 1'b0;
        neg_elems   = 0;
        size_reg    = SIZE_RESET;
        foreach (elem_mem[i])
            elem_mem[i] = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows; the store sweep after reset holds off the first one
        foreach (directed_tbl[i])
        begin
            if (directed_tbl[i].size != size_reg)
                set_size(directed_tbl[i].size);
            send_req(directed_tbl[i].req, directed_tbl[i].typed, directed_tbl[i].want);
        end

        foreach (phase_tbl[p])
        begin
            set_size(phase_tbl[p].size);
            steady_flow = phase_tbl[p].steady;
            // the receiver stalls while requests keep coming, so the block
            // fills its result register and stops taking new requests
            hold_req = phase_tbl[p].hold;
            repeat (phase_tbl[p].items)
                send_req(rand_request(active_dim(), phase_tbl[p].neg_pct), 1'b0, '0);
            steady_flow = 1'b0;
            hold_req    = 1'b0;
        end

        in_valid <= 1'b0;
        while (sum_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0 && sum_expect_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Receiver: random stalls, none in a steady phase, and one long hold-off
    // counted here.
    initial
    begin
        out_ready = 1'b0;
        hold_done = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                out_ready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // Scoreboard: each result taken is checked against the oldest prediction.
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (sum_expect_q.size() == 0)
            begin
                $display("%0t: unexpected result: abs_sum %0d any_negative %0b",
                         $time, out_data.abs_sum, out_data.any_negative);
                errors++;
            end
            else
            begin
                want = sum_expect_q.pop_front();
                if (out_data.abs_sum !== want.abs_sum)
                begin
                    $display("%0t: abs_sum mismatch: expected %0d, actual %0d",
                             $time, want.abs_sum, out_data.abs_sum);
                    errors++;
                end
                if (out_data.any_negative !== want.any_negative)
                begin
                    $display("%0t: any_negative mismatch: expected %0b, actual %0b",
                             $time, want.any_negative, out_data.any_negative);
                    errors++;
                end
            end
        end
    end

    // Watchdog: too long without any handshake means the block is stuck.
    always @(posedge clk)
    begin
        if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            stall_cycles = 0;
        end
        else if (stall_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
        else
        begin
            stall_cycles = stall_cycles + 1;
        end
    end

    initial
    begin
        stall_cycles = 0;
    end

endmodule
